/* src/sajpd_pkg.sv */
package sajpd_pkg;

    localparam logic [7:0] CH_ESC    = 8'h5E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DATA   = 8'h44;
    localparam logic [7:0] CH_BUTTON = 8'h2E;

    localparam logic [4:0] ESC_MASK  = 5'h1F;
    localparam int         NUM_AXES  = 6;
    localparam int         AXIS_W    = 16;
    localparam int         LAST_AXIS_BYTE = 14;
    localparam int         FIRST_AXIS_BYTE = 3;

    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_MOTION = 2'd1,
        KIND_BUTTON = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                          kind;
        logic [NUM_AXES-1:0][AXIS_W-1:0] axes;
        logic [7:0]                     btn0;
        logic [7:0]                     btn1;
    } packet_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] level;
    } queue_status_t;

    function automatic logic [AXIS_W-1:0] neg_sat16(input logic [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] r;
        if (v == {1'b1, {(AXIS_W-1){1'b0}}})
        begin
            r = {1'b0, {(AXIS_W-1){1'b1}}};
        end
        else
        begin
            r = (~v) + AXIS_W'(1);
        end
        return r;
    endfunction

endpackage

/* src/six_axis_joystick_packet_decoder_unit.sv */
// Decodes the byte stream of a six-axis joystick into packets. One byte is
// taken per clock cycle; a closed packet is decoded in the cycle its last
// byte arrives and passes through a two-item queue to an output register,
// so a result is registered in the queue and then in the output register.
// Input is held off only while the queue is full, which takes two results
// waiting behind a stalled output.
module six_axis_joystick_packet_decoder_unit import sajpd_pkg::*; #(
    parameter int MAX_PACKET = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         packet_kind,
    output logic signed [15:0] trans_x,
    output logic signed [15:0] trans_y,
    output logic signed [15:0] trans_z,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z,
    output logic [11:0]        button_mask
);

    logic          push_valid;
    logic          push_ready;
    packet_t       push_data;
    logic          pop_valid;
    logic          pop_ready;
    packet_t       pop_data;
    queue_status_t q_status;

    sajpd_front #(
        .MAX_PACKET(MAX_PACKET)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte (rx_byte),
        .q_ready (push_ready),
        .q_valid (push_valid),
        .q_data  (push_data)
    );

    sajpd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_data),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (pop_data),
        .status  (q_status)
    );

    sajpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_data     (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .packet_kind(packet_kind),
        .trans_x    (trans_x),
        .trans_y    (trans_y),
        .trans_z    (trans_z),
        .rot_x      (rot_x),
        .rot_y      (rot_y),
        .rot_z      (rot_z),
        .button_mask(button_mask)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= 2'(QUEUE_DEPTH))
        else $error("queue level exceeds its depth");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && !out_valid) |=> out_valid)
        else $error("queued packet not moved to an empty output register");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && push_valid) |-> !q_status.full)
        else $error("packet closed while the queue is full");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.empty && !push_valid && !(out_valid && !out_ready))
        |=> q_status.empty)
        else $error("queue filled without a packet being pushed");

endmodule

/* src/sajpd_front.sv */
module sajpd_front import sajpd_pkg::*; #(
    parameter int MAX_PACKET = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       q_ready,
    output logic       q_valid,
    output packet_t    q_data
);

    localparam int CNT_W = $clog2(MAX_PACKET);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(MAX_PACKET - 1);

    logic                           esc_reg, esc_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [7:0]                     type_reg, type_next;
    logic [7:0]                     hold_reg, hold_next;
    logic [NUM_AXES-1:0][AXIS_W-1:0] axes_reg, axes_next;
    logic [7:0]                     btn0_reg, btn0_next;
    logic [7:0]                     btn1_reg, btn1_next;

    logic             store;
    logic             close;
    logic             fire;
    logic [7:0]       b;
    logic [CNT_W-1:0] off;
    logic [2:0]       ax;

    assign in_ready = q_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        esc_next  = esc_reg;
        cnt_next  = cnt_reg;
        type_next = type_reg;
        hold_next = hold_reg;
        axes_next = axes_reg;
        btn0_next = btn0_reg;
        btn1_next = btn1_reg;
        store     = 1'b0;
        close     = 1'b0;
        b         = rx_byte;
        off       = cnt_reg - CNT_W'(FIRST_AXIS_BYTE);
        ax        = off[3:1];

        if (esc_reg)
        begin
            store    = 1'b1;
            esc_next = 1'b0;
            if (rx_byte != CH_ESC)
            begin
                b = {3'b000, rx_byte[4:0] & ESC_MASK};
            end
        end
        else if (rx_byte == CH_ESC)
        begin
            esc_next = 1'b1;
        end
        else if (rx_byte == CH_CR)
        begin
            close = 1'b1;
        end
        else
        begin
            store = 1'b1;
        end

        if (store)
        begin
            if (cnt_reg == '0)
            begin
                type_next = b;
            end
            else if (cnt_reg == CNT_W'(1))
            begin
                btn0_next = b;
            end
            else if (cnt_reg == CNT_W'(2))
            begin
                btn1_next = b;
            end
            else if (cnt_reg <= CNT_W'(LAST_AXIS_BYTE))
            begin
                if (!off[0])
                begin
                    hold_next     = b;
                    axes_next[ax] = {b, 8'h00};
                end
                else
                begin
                    axes_next[ax] = {hold_reg, b};
                end
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cnt_next == LAST_COUNT)
        begin
            close = 1'b1;
        end
    end

    always_comb
    begin
        q_data.axes = axes_next;
        q_data.btn0 = btn0_next;
        q_data.btn1 = btn1_next;
        unique case (type_next)
            CH_DATA:   q_data.kind = KIND_MOTION;
            CH_BUTTON: q_data.kind = KIND_BUTTON;
            default:   q_data.kind = KIND_OTHER;
        endcase
    end

    assign q_valid = fire && close;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= 1'b0;
            cnt_reg  <= '0;
            type_reg <= '0;
            hold_reg <= '0;
            axes_reg <= '0;
            btn0_reg <= '0;
            btn1_reg <= '0;
        end
        else if (fire)
        begin
            if (close)
            begin
                esc_reg  <= 1'b0;
                cnt_reg  <= '0;
                type_reg <= '0;
                hold_reg <= '0;
                axes_reg <= '0;
                btn0_reg <= '0;
                btn1_reg <= '0;
            end
            else
            begin
                esc_reg  <= esc_next;
                cnt_reg  <= cnt_next;
                type_reg <= type_next;
                hold_reg <= hold_next;
                axes_reg <= axes_next;
                btn0_reg <= btn0_next;
                btn1_reg <= btn1_next;
            end
        end
    end

endmodule

/* src/sajpd_queue.sv */
module sajpd_queue import sajpd_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  packet_t       wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output packet_t       rd_data,
    output queue_status_t status
);

    packet_t    mem [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;
    logic       push;
    logic       pop;

    assign status.full  = (level_reg == 2'(QUEUE_DEPTH));
    assign status.empty = (level_reg == 2'd0);
    assign status.level = level_reg;

    assign wr_ready = !status.full;
    assign rd_valid = !status.empty;
    assign rd_data  = mem[rd_ptr_reg];

    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/sajpd_back.sv */
module sajpd_back import sajpd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  packet_t            q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         packet_kind,
    output logic signed [15:0] trans_x,
    output logic signed [15:0] trans_y,
    output logic signed [15:0] trans_z,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z,
    output logic [11:0]        button_mask
);

    logic        out_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [NUM_AXES-1:0][AXIS_W-1:0] axes_reg, axes_next;
    logic [11:0] mask_reg, mask_next;
    logic        pop;

    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        kind_next = q_data.kind;
        axes_next = '0;
        mask_next = '0;
        unique case (q_data.kind)
            KIND_MOTION:
            begin
                axes_next[0] = q_data.axes[0];
                axes_next[1] = q_data.axes[1];
                axes_next[2] = neg_sat16(q_data.axes[2]);
                axes_next[3] = q_data.axes[3];
                axes_next[4] = q_data.axes[4];
                axes_next[5] = neg_sat16(q_data.axes[5]);
            end
            KIND_BUTTON:
            begin
                mask_next = {q_data.btn0[4:0], q_data.btn1[7], q_data.btn1[5:0]};
            end
            default:
            begin
                kind_next = KIND_OTHER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_ready)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= kind_next;
            axes_reg <= axes_next;
            mask_reg <= mask_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_kind = kind_reg;
    assign trans_x     = axes_reg[0];
    assign trans_y     = axes_reg[1];
    assign trans_z     = axes_reg[2];
    assign rot_x       = axes_reg[3];
    assign rot_y       = axes_reg[4];
    assign rot_z       = axes_reg[5];
    assign button_mask = mask_reg;

endmodule
